/* rtl/gf2ss_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gf2ss_pkg
// Shared types and codes of the GF(2) switch system solver.
// ----------------------------------------------------------------------------
package gf2ss_pkg;

	localparam int NUM_W = 6;
	localparam int IDX_W = 5;
	localparam int REQ_W = 2;
	localparam int CNT_W = 33;

	localparam logic [REQ_W-1:0] REQ_STATE = 2'd0;
	localparam logic [REQ_W-1:0] REQ_LINK  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SOLVE = 2'd2;

	typedef struct packed {
		logic [REQ_W-1:0] req_type;
		logic [IDX_W-1:0] first_index;
		logic [IDX_W-1:0] second_index;
		logic             start_bit;
		logic             end_bit;
	} in_word_t;

	typedef struct packed {
		logic             solvable;
		logic [CNT_W-1:0] solution_count;
		logic [NUM_W-1:0] free_vars;
	} out_word_t;

endpackage
`default_nettype wire

/* rtl/gf2_switch_system_solver.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gf2_switch_system_solver
// GF(2) linear system builder and Gaussian elimination solver.
// ----------------------------------------------------------------------------
// Rows of the system live in a one-port-read, one-port-write memory with a
// registered read. A state or link word reads the row, then writes it back.
// A solve word walks the rows one memory read per cycle: for each column a
// pivot search, an optional swap in the SWAP and SWAP2 states and an
// elimination pass over the rows below, then a consistency check over the
// rows without pivot. It waits in DONE while the previous result still sits
// in the output register. The result sits in an output register; once it is
// loaded the row store is cleared in the same cycle and the next word can be
// taken.
// ----------------------------------------------------------------------------
module gf2_switch_system_solver
	import gf2ss_pkg::*;
#(
	parameter int MAX_SWITCHES = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wr_en,
	input  wire logic [NUM_W-1:0] cfg_wr_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_word_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_word_t             out_data
);

	localparam int RW  = MAX_SWITCHES + 1;
	localparam int AW  = $clog2(MAX_SWITCHES);
	localparam int RHS = MAX_SWITCHES;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOAD  = 3'd1;
	localparam logic [2:0] ST_SRCH  = 3'd2;
	localparam logic [2:0] ST_SWAP  = 3'd3;
	localparam logic [2:0] ST_SWAP2 = 3'd4;
	localparam logic [2:0] ST_ELIM  = 3'd5;
	localparam logic [2:0] ST_CHK   = 3'd6;
	localparam logic [2:0] ST_DONE  = 3'd7;

	localparam logic [RW-1:0] RHS_BIT = RW'(1) << RHS;

	logic [2:0]       state_q, state_d;
	logic [NUM_W-1:0] num_sw_q;
	logic [NUM_W-1:0] n;
	logic [NUM_W-1:0] j_q, j_d, pr_q, pr_d, pc_q, pc_d, found_q, found_d;
	logic [RW-1:0]    col_q, col_d, piv_q, piv_d, mask_q, mask_d;
	logic             ok_q, ok_d;
	in_word_t         item_q;
	logic             out_valid_q, out_valid_d;
	out_word_t        out_q, out_d;

	logic             mem_we, mem_clr;
	logic [NUM_W-1:0] mem_wa, mem_ra;
	logic [RW-1:0]    mem_wd, mem_rd, row_m;

	logic             accept;
	logic             adv;
	logic [NUM_W-1:0] adv_pr;
	logic [NUM_W-1:0] j_nx;
	logic [NUM_W-1:0] a_ext, b_ext, free_cnt;
	logic             hit;

	assign n = (num_sw_q > NUM_W'(MAX_SWITCHES)) ? NUM_W'(MAX_SWITCHES) : num_sw_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign row_m    = mem_rd & mask_q;
	assign hit      = |(row_m & col_q);
	assign j_nx     = j_q + NUM_W'(1);
	assign a_ext    = NUM_W'(in_data.first_index);
	assign b_ext    = NUM_W'(in_data.second_index);
	assign free_cnt = n - pr_q;

	gf2ss_row_mem #(
		.DEPTH (MAX_SWITCHES),
		.WIDTH (RW)
	) u_row_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.clr     (mem_clr),
		.wr_en   (mem_we),
		.wr_addr (mem_wa[AW-1:0]),
		.wr_data (mem_wd),
		.rd_addr (mem_ra[AW-1:0]),
		.rd_data (mem_rd)
	);

	always_comb begin
		state_d     = state_q;
		j_d         = j_q;
		pr_d        = pr_q;
		pc_d        = pc_q;
		found_d     = found_q;
		col_d       = col_q;
		piv_d       = piv_q;
		mask_d      = mask_q;
		ok_d        = ok_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && out_stall;
		mem_we      = 1'b0;
		mem_clr     = 1'b0;
		mem_wa      = '0;
		mem_wd      = '0;
		mem_ra      = '0;
		adv         = 1'b0;
		adv_pr      = pr_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (in_data.req_type)
						REQ_STATE: begin
							mem_ra = a_ext;
							if (a_ext < n) begin
								state_d = ST_LOAD;
							end
						end
						REQ_LINK: begin
							mem_ra = b_ext;
							if (a_ext < n && b_ext < n) begin
								state_d = ST_LOAD;
							end
						end
						REQ_SOLVE: begin
							mask_d = ~({RW{1'b1}} << n) | RHS_BIT;
							pr_d   = '0;
							pc_d   = '0;
							j_d    = '0;
							col_d  = RW'(1);
							ok_d   = 1'b1;
							mem_ra = '0;
							state_d = (n == '0) ? ST_DONE : ST_SRCH;
						end
						default: begin
							// unknown request: drop
						end
					endcase
				end
			end
			ST_LOAD: begin
				mem_we = 1'b1;
				if (item_q.req_type == REQ_STATE) begin
					mem_wa = NUM_W'(item_q.first_index);
					mem_wd = (mem_rd & ~RHS_BIT) | (RW'(1) << item_q.first_index)
						| ((item_q.start_bit ^ item_q.end_bit) ? RHS_BIT : '0);
				end else begin
					mem_wa = NUM_W'(item_q.second_index);
					mem_wd = mem_rd | (RW'(1) << item_q.first_index);
				end
				state_d = ST_IDLE;
			end
			ST_SRCH: begin
				if (hit) begin
					piv_d   = row_m;
					found_d = j_q;
					if (j_q != pr_q) begin
						mem_ra  = pr_q;
						state_d = ST_SWAP;
					end else if (j_nx < n) begin
						j_d     = j_nx;
						mem_ra  = j_nx;
						state_d = ST_ELIM;
					end else begin
						adv    = 1'b1;
						adv_pr = pr_q + NUM_W'(1);
					end
				end else if (j_nx < n) begin
					j_d    = j_nx;
					mem_ra = j_nx;
				end else begin
					adv = 1'b1;
				end
			end
			ST_SWAP: begin
				// old pivot-row contents move down to where the pivot was found
				mem_we  = 1'b1;
				mem_wa  = found_q;
				mem_wd  = row_m;
				state_d = ST_SWAP2;
			end
			ST_SWAP2: begin
				mem_we = 1'b1;
				mem_wa = pr_q;
				mem_wd = piv_q;
				// rows between the pivot row and the found row have no bit here
				if (found_q + NUM_W'(1) < n) begin
					j_d     = found_q + NUM_W'(1);
					mem_ra  = found_q + NUM_W'(1);
					state_d = ST_ELIM;
				end else begin
					adv    = 1'b1;
					adv_pr = pr_q + NUM_W'(1);
				end
			end
			ST_ELIM: begin
				if (hit) begin
					mem_we = 1'b1;
					mem_wa = j_q;
					mem_wd = row_m ^ piv_q;
				end
				if (j_nx < n) begin
					j_d    = j_nx;
					mem_ra = j_nx;
				end else begin
					adv    = 1'b1;
					adv_pr = pr_q + NUM_W'(1);
				end
			end
			ST_CHK: begin
				if ((row_m & RHS_BIT) != '0) begin
					ok_d = 1'b0;
				end
				if (j_nx < n) begin
					j_d    = j_nx;
					mem_ra = j_nx;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold until the output register is free
				if (!out_valid_q || !out_stall) begin
					out_d.solvable       = ok_q;
					out_d.solution_count = ok_q ? (CNT_W'(1) << free_cnt) : '0;
					out_d.free_vars      = free_cnt;
					out_valid_d          = 1'b1;
					mem_clr              = 1'b1;
					pr_d                 = '0;
					pc_d                 = '0;
					state_d              = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// advance to the next column
		if (adv) begin
			pr_d  = adv_pr;
			pc_d  = pc_q + NUM_W'(1);
			col_d = col_q << 1;
			if (adv_pr < n) begin
				j_d     = adv_pr;
				mem_ra  = adv_pr;
				state_d = (pc_q + NUM_W'(1) < n) ? ST_SRCH : ST_CHK;
			end else begin
				state_d = ST_DONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			num_sw_q    <= NUM_W'(1);
			j_q         <= '0;
			pr_q        <= '0;
			pc_q        <= '0;
			ok_q        <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			j_q         <= j_d;
			pr_q        <= pr_d;
			pc_q        <= pc_d;
			ok_q        <= ok_d;
			out_valid_q <= out_valid_d;
			if (cfg_wr_en) begin
				num_sw_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= in_data;
		end
		found_q <= found_d;
		col_q   <= col_d;
		piv_q   <= piv_d;
		mask_q  <= mask_d;
		out_q   <= out_d;
	end

endmodule
`default_nettype wire

/* rtl/gf2ss_row_mem.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// gf2ss_row_mem
// Equation row store: one write and one registered read per cycle, with
// write-to-read bypass and per-row valid bits that reset and clear at once.
// ----------------------------------------------------------------------------
module gf2ss_row_mem #(
	parameter int DEPTH = 32,
	parameter int WIDTH = 33
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     clr,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [WIDTH-1:0] rd_q;
	logic             rd_vld_q;
	logic             bypass;

	assign bypass  = wr_en && (wr_addr == rd_addr);
	assign rd_data = rd_vld_q ? rd_q : '0;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= bypass ? wr_data : mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			rd_vld_q <= vld_q[rd_addr] | bypass;
			if (clr) begin
				vld_q <= '0;
			end else if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire
